[rtl/nsfe_pkg.sv]
package nsfe_pkg;

  // Configuration register indexes
  localparam logic CfgGgaMask = 1'b0;
  localparam logic CfgGsaMask = 1'b1;

  localparam int unsigned MaskW = 16;
  localparam logic [MaskW-1:0] GgaMaskRst = 16'd1598;
  localparam logic [MaskW-1:0] GsaMaskRst = 16'd2040;

  // Result kinds and sentence types
  localparam logic KindData = 1'b0;
  localparam logic KindEnd  = 1'b1;
  localparam logic TypeGga  = 1'b0;
  localparam logic TypeGsa  = 1'b1;

  // ASCII characters of interest
  localparam logic [7:0] ChDollar = 8'h24;
  localparam logic [7:0] ChStar   = 8'h2A;
  localparam logic [7:0] ChComma  = 8'h2C;
  localparam logic [7:0] ChG      = 8'h47;
  localparam logic [7:0] ChP      = 8'h50;
  localparam logic [7:0] ChS      = 8'h53;
  localparam logic [7:0] ChA      = 8'h41;
  localparam logic [7:0] ChCr     = 8'h0D;
  localparam logic [7:0] ChLf     = 8'h0A;

  typedef struct packed {
    logic       kind;
    logic       sentence_type;
    logic [4:0] field_number;
    logic [5:0] char_position;
    logic [7:0] data_byte;
    logic [7:0] xor_sum;
  } result_t;

endpackage

[rtl/nsfe_parser.sv]
module nsfe_parser
  import nsfe_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             step_i,
  input  logic [7:0]       rx_byte_i,
  input  logic [MaskW-1:0] gga_mask_i,
  input  logic [MaskW-1:0] gsa_mask_i,
  output logic             res_valid_o,
  output result_t          res_o
);

  localparam logic [1:0] PhIdle   = 2'd0;
  localparam logic [1:0] PhHeader = 2'd1;
  localparam logic [1:0] PhBody   = 2'd2;
  localparam logic [1:0] PhSkip   = 2'd3;

  logic [1:0] phase_q, phase_d;
  logic [2:0] hcnt_q, hcnt_d;
  logic       hok_q, hok_d;
  logic       type_q, type_d;
  logic [4:0] field_q, field_d;
  logic [5:0] pos_q, pos_d;
  logic [7:0] xor_q, xor_d;

  logic             char_ok;
  logic             hok_n;
  logic [MaskW-1:0] mask;
  logic [5:0]       pos_inc;

  always_comb begin
    unique case (hcnt_q)
      3'd0:    char_ok = (rx_byte_i == ChG);
      3'd1:    char_ok = (rx_byte_i == ChP);
      3'd2:    char_ok = (rx_byte_i == ChG);
      3'd3:    char_ok = (rx_byte_i == ChG) || (rx_byte_i == ChS);
      3'd4:    char_ok = (rx_byte_i == ChA);
      default: char_ok = 1'b0;
    endcase
  end

  assign hok_n   = hok_q & char_ok;
  assign mask    = type_q ? gsa_mask_i : gga_mask_i;
  assign pos_inc = (pos_q < 6'd63) ? pos_q + 6'd1 : pos_q;

  always_comb begin
    phase_d     = phase_q;
    hcnt_d      = hcnt_q;
    hok_d       = hok_q;
    type_d      = type_q;
    field_d     = field_q;
    pos_d       = pos_q;
    xor_d       = xor_q;
    res_valid_o = 1'b0;
    res_o       = '{kind: KindData, sentence_type: type_q, field_number: field_q,
                    char_position: pos_q, data_byte: rx_byte_i, xor_sum: 8'd0};

    priority if (rx_byte_i == ChDollar) begin
      phase_d = PhHeader;
      hcnt_d  = 3'd0;
      hok_d   = 1'b1;
      type_d  = TypeGga;
      field_d = 5'd0;
      pos_d   = 6'd0;
      xor_d   = 8'd0;
    end else if (phase_q == PhIdle) begin
      // drop bytes outside a sentence
    end else if (rx_byte_i == ChCr || rx_byte_i == ChLf) begin
      phase_d = PhIdle;
    end else if (rx_byte_i == ChStar) begin
      phase_d = PhIdle;
      if (phase_q == PhBody) begin
        res_valid_o     = 1'b1;
        res_o.kind      = KindEnd;
        res_o.data_byte = 8'd0;
        res_o.xor_sum   = xor_q;
      end
    end else begin
      xor_d = xor_q ^ rx_byte_i;
      unique case (phase_q)
        PhHeader: begin
          hok_d  = hok_n;
          hcnt_d = hcnt_q + 3'd1;
          if (hcnt_q == 3'd3) begin
            type_d = (rx_byte_i == ChS) ? TypeGsa : TypeGga;
          end
          if (hcnt_q == 3'd4) begin
            phase_d = hok_n ? PhBody : PhSkip;
            field_d = 5'd0;
            pos_d   = 6'd5;
          end
        end
        PhBody: begin
          if (rx_byte_i == ChComma) begin
            if (field_q < 5'd31) begin
              field_d = field_q + 5'd1;
            end
            pos_d = 6'd0;
          end else begin
            pos_d = pos_inc;
            if (!field_q[4] && mask[field_q[3:0]]) begin
              res_valid_o = 1'b1;
            end
          end
        end
        default: begin
          // skipped sentence: hold
        end
      endcase
    end

    if (!step_i) begin
      res_valid_o = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhIdle;
      hcnt_q  <= 3'd0;
      hok_q   <= 1'b0;
      type_q  <= TypeGga;
      field_q <= 5'd0;
      pos_q   <= 6'd0;
      xor_q   <= 8'd0;
    end else if (step_i) begin
      phase_q <= phase_d;
      hcnt_q  <= hcnt_d;
      hok_q   <= hok_d;
      type_q  <= type_d;
      field_q <= field_d;
      pos_q   <= pos_d;
      xor_q   <= xor_d;
    end
  end

endmodule

[rtl/nsfe_out_reg.sv]
module nsfe_out_reg
  import nsfe_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    load_i,
  input  result_t res_i,
  input  logic    ready_i,
  output logic    free_o,
  output logic    valid_o,
  output result_t res_o
);

  logic    valid_q;
  result_t res_q;

  assign free_o  = !valid_q || ready_i;
  assign valid_o = valid_q;
  assign res_o   = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= 1'b1;
    end else if (ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

endmodule

[rtl/nmea_sentence_field_extractor.sv]
// NMEA sentence field extractor.
// Slave stream: one received character per transfer in s_axis_tdata.
// Master stream: one transfer per emitted result. tuser says whether the
// transfer carries a field data byte (bit 0 low) or the end of a sentence
// with its running XOR checksum (bit 0 high), and whether the sentence is
// GGA or GSA (bit 1). tdata carries field number, position, data byte and
// checksum. Characters that produce nothing (headers, commas, skipped
// sentences, idle bytes) are consumed silently.
// Path: a character is parsed combinationally while it sits in the input
// register; its result is loaded into the output register when the parser
// steps, and m_axis_tvalid is driven from that register. Throughput is one
// character per cycle while the output register can take a result, bounded
// by the single parse step between the registers.
// Stall: when the receiver holds m_axis_tready low with a result pending,
// the parser freezes; one more character may enter an empty input register,
// then s_axis_tready drops until the result is taken.
// Reset: clears the parser to idle (waiting for '$'), empties both
// registers and restores the field masks to their defaults. Mask writes
// on the cfg port take effect at once and belong between sentences.
module nmea_sentence_field_extractor
  import nsfe_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  // configuration write port
  input  logic             cfg_we_i,
  input  logic             cfg_idx_i,
  input  logic [MaskW-1:0] cfg_data_i,
  // input stream
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  input  logic [7:0]       s_axis_tdata,   // [7:0] rx_byte
  // result stream
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  output logic [31:0]      m_axis_tdata,   // [4:0] field_number, [10:5] char_position,
                                           // [18:11] data_byte, [26:19] xor_sum, rest 0
  output logic [1:0]       m_axis_tuser    // [0] kind, [1] sentence_type
);

  logic [MaskW-1:0] gga_mask_q, gsa_mask_q;
  logic             in_valid_q;
  logic [7:0]       in_byte_q;
  logic             step;
  logic             out_free;
  logic             res_valid;
  result_t          res, out_res;

  // Field masks
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gga_mask_q <= GgaMaskRst;
      gsa_mask_q <= GsaMaskRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgGgaMask: gga_mask_q <= cfg_data_i;
        CfgGsaMask: gsa_mask_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Advance the held character whenever the output register is free,
  // whether or not the character produces a result.
  assign step          = in_valid_q && out_free;
  assign s_axis_tready = !in_valid_q || out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_byte_q <= s_axis_tdata;
    end
  end

  nsfe_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .rx_byte_i   (in_byte_q),
    .gga_mask_i  (gga_mask_q),
    .gsa_mask_i  (gsa_mask_q),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  nsfe_out_reg u_out_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (res_valid),
    .res_i   (res),
    .ready_i (m_axis_tready),
    .free_o  (out_free),
    .valid_o (m_axis_tvalid),
    .res_o   (out_res)
  );

  assign m_axis_tuser = {out_res.sentence_type, out_res.kind};
  assign m_axis_tdata = {5'd0, out_res.xor_sum, out_res.data_byte,
                         out_res.char_position, out_res.field_number};

endmodule
